### hdl/bvf_pkg.sv
// Package for the bounded value FIFO with purge.
// Holds field widths, request and register codes, and controller/datapath structs.
// No dependencies.
package bvf_pkg;

  localparam int unsigned BVF_DEPTH = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned CNT_OUT_W = 5;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_PURGE = 2'd2
  } bvf_req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VALUE_BOUND      = 1'b0,
    REG_EMPTY_READ_VALUE = 1'b1
  } bvf_reg_e;

  typedef struct packed {
    logic accept;
    logic load_now;
    logic rd_finish;
    logic purge_step;
    logic purge_finish;
  } bvf_cmd_t;

  typedef struct packed {
    logic empty;
    logic purge_done;
  } bvf_sts_t;

endpackage

### hdl/bvf_if.sv
// Channel interfaces for request, response and configuration.
// Depends on bvf_pkg.
interface bvf_req_if import bvf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [DATA_W-1:0] data_in;

  modport source (output valid, output req_type, output data_in, input ready);
  modport sink   (input valid, input req_type, input data_in, output ready);
endinterface

interface bvf_rsp_if import bvf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_data;
  logic                     read_was_empty;
  logic                     write_accepted;
  logic                     write_dropped_full;
  logic [CNT_OUT_W-1:0]     purged_count;
  logic [CNT_OUT_W-1:0]     fill_level;

  modport source (output valid, output read_data, output read_was_empty,
                  output write_accepted, output write_dropped_full,
                  output purged_count, output fill_level, input ready);
  modport sink   (input valid, input read_data, input read_was_empty,
                  input write_accepted, input write_dropped_full,
                  input purged_count, input fill_level, output ready);
endinterface

interface bvf_cfg_if import bvf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/bvf_ctrl.sv
// Controller state machine of the bounded value FIFO.
// Sequences reads and purges and owns the response valid. Depends on bvf_pkg.
module bvf_ctrl import bvf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  input  logic [REQ_W-1:0] req_type_i,
  output logic             req_ready_o,
  output logic             rsp_valid_o,
  input  logic             rsp_ready_i,
  input  bvf_sts_t         sts_i,
  output bvf_cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_RD_WAIT = 3'b010,
    ST_PURGE   = 3'b100
  } state_e;

  state_e   state_q, state_d;
  logic     rsp_valid_q, rsp_valid_d;
  logic     immediate;
  bvf_cmd_t cmd;

  assign req_ready_o = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_ready_i);
  assign rsp_valid_o = rsp_valid_q;
  assign cmd_o       = cmd;

  always_comb begin
    immediate = !((req_type_i == REQ_PURGE) || ((req_type_i == REQ_READ) && !sts_i.empty));
    cmd = '0;
    state_d = state_q;
    cmd.accept = req_valid_i && req_ready_o;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd.accept) begin
          cmd.load_now = immediate;
          if (req_type_i == REQ_PURGE) begin
            state_d = ST_PURGE;
          end else if (!immediate) begin
            state_d = ST_RD_WAIT;
          end
        end
      end
      ST_RD_WAIT: begin
        cmd.rd_finish = 1'b1;
        state_d = ST_IDLE;
      end
      ST_PURGE: begin
        cmd.purge_step = 1'b1;
        if (sts_i.purge_done) begin
          cmd.purge_finish = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (cmd.load_now || cmd.rd_finish || cmd.purge_finish) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  a_rd_wait_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RD_WAIT |=> rsp_valid_q && state_q == ST_IDLE)
    else $error("read did not complete after one wait cycle");

  a_purge_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept && req_type_i == REQ_PURGE |=> state_q == ST_PURGE && !rsp_valid_q)
    else $error("purge request did not enter purge walk with empty response slot");

endmodule

### hdl/bvf_dp.sv
// Datapath of the bounded value FIFO: entry memory, pointers, config and response.
// Driven by bvf_ctrl commands. Depends on bvf_pkg.
module bvf_dp import bvf_pkg::*; #(
  parameter int unsigned DEPTH = BVF_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bvf_cmd_t                    cmd_i,
  output bvf_sts_t                    sts_o,
  input  logic [REQ_W-1:0]            req_type_i,
  input  logic signed [DATA_W-1:0]    data_in_i,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [DATA_W-1:0]           cfg_data_i,
  output logic signed [DATA_W-1:0]    read_data_o,
  output logic                        read_was_empty_o,
  output logic                        write_accepted_o,
  output logic                        write_dropped_full_o,
  output logic [CNT_OUT_W-1:0]        purged_count_o,
  output logic [CNT_OUT_W-1:0]        fill_level_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [CW:0] sum;
    begin
      sum = (CW+1)'(base) + (CW+1)'(off);
      if (sum >= (CW+1)'(DEPTH)) begin
        sum = sum - (CW+1)'(DEPTH);
      end
      return sum[AW-1:0];
    end
  endfunction

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] mem_rdata_q;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata;

  logic [AW-1:0]     head_q, head_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     kept_q, kept_d;
  logic              pvld_q, pvld_d;
  logic signed [DATA_W-1:0] bound_q, empty_val_q;

  logic signed [DATA_W-1:0] rd_data_q, rd_data_d;
  logic                     was_empty_q, was_empty_d;
  logic                     acc_q, acc_d;
  logic                     drop_q, drop_d;
  logic [CW-1:0]            purged_q, purged_d;
  logic [CW-1:0]            fill_q;
  logic                     load_out;

  assign sts_o.empty      = (count_q == '0);
  assign sts_o.purge_done = (idx_q == count_q) && !pvld_q;
  assign load_out = cmd_i.load_now || cmd_i.rd_finish || cmd_i.purge_finish;

  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    idx_d       = idx_q;
    kept_d      = kept_q;
    pvld_d      = pvld_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = slot_of(head_q, count_q);
    mem_raddr   = head_q;
    mem_wdata   = data_in_i;
    rd_data_d   = '0;
    was_empty_d = 1'b0;
    acc_d       = 1'b0;
    drop_d      = 1'b0;
    purged_d    = '0;

    if (cmd_i.accept) begin
      unique case (req_type_i)
        REQ_WRITE: begin
          if (data_in_i < bound_q) begin
            if (count_q < CW'(DEPTH)) begin
              mem_we  = 1'b1;
              count_d = count_q + CW'(1);
              acc_d   = 1'b1;
            end else begin
              drop_d = 1'b1;
            end
          end
        end
        REQ_READ: begin
          if (count_q != '0) begin
            mem_re  = 1'b1;
            head_d  = slot_of(head_q, CW'(1));
            count_d = count_q - CW'(1);
          end else begin
            rd_data_d   = empty_val_q;
            was_empty_d = 1'b1;
          end
        end
        REQ_PURGE: begin
          idx_d  = '0;
          kept_d = '0;
          pvld_d = 1'b0;
        end
        default: ;
      endcase
    end

    if (cmd_i.rd_finish) begin
      rd_data_d = mem_rdata_q;
    end

    if (cmd_i.purge_step) begin
      if (pvld_q && ($signed(mem_rdata_q) < bound_q)) begin
        mem_we    = 1'b1;
        mem_waddr = slot_of(head_q, kept_q);
        mem_wdata = mem_rdata_q;
        kept_d    = kept_q + CW'(1);
      end
      if (idx_q < count_q) begin
        mem_re    = 1'b1;
        mem_raddr = slot_of(head_q, idx_q);
        idx_d     = idx_q + CW'(1);
        pvld_d    = 1'b1;
      end else begin
        pvld_d = 1'b0;
      end
    end

    if (cmd_i.purge_finish) begin
      count_d  = kept_q;
      purged_d = count_q - kept_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      kept_q      <= '0;
      pvld_q      <= 1'b0;
      bound_q     <= '0;
      empty_val_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      kept_q  <= kept_d;
      pvld_q  <= pvld_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_VALUE_BOUND:      bound_q     <= cfg_data_i;
          REG_EMPTY_READ_VALUE: empty_val_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      rd_data_q   <= rd_data_d;
      was_empty_q <= was_empty_d;
      acc_q       <= acc_d;
      drop_q      <= drop_d;
      purged_q    <= purged_d;
      fill_q      <= count_d;
    end
  end

  assign read_data_o          = rd_data_q;
  assign read_was_empty_o     = was_empty_q;
  assign write_accepted_o     = acc_q;
  assign write_dropped_full_o = drop_q;
  assign purged_count_o       = CNT_OUT_W'(purged_q);
  assign fill_level_o         = CNT_OUT_W'(fill_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH) && (CW+1)'(head_q) < (CW+1)'(DEPTH))
    else $error("fill count or head pointer out of range");

  a_purge_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pvld_q |-> kept_q < idx_q && idx_q <= count_q)
    else $error("purge compaction overtook its read pointer");

endmodule

### hdl/bounded_value_fifo_with_purge.sv
// Bounded value FIFO with purge, top level. A write, an empty read or an unused code
// answers in the cycle after acceptance, and writes go back to back at one per cycle
// while responses are taken. A read of a held entry answers through the registered
// memory read port and the read-wait state. A purge walks the held entries once and
// answers when the walk is done, taking no request until then.
// Reset (async, active low) clears pointers, count and config; memory is not cleared.
module bounded_value_fifo_with_purge import bvf_pkg::*; #(
  parameter int unsigned DEPTH = BVF_DEPTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  bvf_req_if.sink   req_i,
  bvf_rsp_if.source rsp_o,
  bvf_cfg_if.sink   cfg_i
);

  bvf_cmd_t cmd;
  bvf_sts_t sts;

  assign cfg_i.ready = 1'b1;

  bvf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bvf_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .req_type_i           (req_i.req_type),
    .data_in_i            (req_i.data_in),
    .cfg_we_i             (cfg_i.valid),
    .cfg_index_i          (cfg_i.index),
    .cfg_data_i           (cfg_i.data),
    .read_data_o          (rsp_o.read_data),
    .read_was_empty_o     (rsp_o.read_was_empty),
    .write_accepted_o     (rsp_o.write_accepted),
    .write_dropped_full_o (rsp_o.write_dropped_full),
    .purged_count_o       (rsp_o.purged_count),
    .fill_level_o         (rsp_o.fill_level)
  );

endmodule
